FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on i_clk, off while in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

FILE: src/mtt_pkg.sv
// ---------------------------------------------------------------------------
// mtt_pkg
// widths, codes and shared types of the move toward target stepper
// ---------------------------------------------------------------------------
package mtt_pkg;

    localparam int PosW     = 24;               // q15.8 position
    localparam int SpdW     = 16;               // q12.4 speed
    localparam int TimeW    = 16;               // q0.16 time step
    localparam int StW      = SpdW + TimeW;     // speed * time, q12.20
    localparam int MulAW    = PosW;             // narrow multiplier operand
    localparam int NumW     = MulAW + StW;      // |d| * st
    localparam int SqW      = 2 * PosW + 1;     // dx^2 + dy^2
    localparam int RootW    = (SqW + 1) / 2;    // floor sqrt
    localparam int DenShift = 12;               // q.20 to q.8
    localparam int QuotW    = StW - DenShift;   // move magnitude bound
    localparam int DvsShift = DenShift + QuotW - 1;
    localparam int RootSteps = RootW;
    localparam int DivSteps  = QuotW;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    // status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

FILE: src/mtt_in_if.sv
// ---------------------------------------------------------------------------
// mtt_in_if
// command channel: load or step, target and motion parameters
// ---------------------------------------------------------------------------
interface mtt_in_if;
    import mtt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic signed [PosW-1:0] target_x;
    logic signed [PosW-1:0] target_y;
    logic [SpdW-1:0]        speed;
    logic [TimeW-1:0]       time_step;

    modport source (output valid, operation, target_x, target_y, speed, time_step,
                    input ready);
    modport sink   (input valid, operation, target_x, target_y, speed, time_step,
                    output ready);
endinterface

FILE: src/mtt_out_if.sv
// ---------------------------------------------------------------------------
// mtt_out_if
// result channel: new position and arrival flag
// ---------------------------------------------------------------------------
interface mtt_out_if;
    import mtt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [PosW-1:0] new_x;
    logic signed [PosW-1:0] new_y;
    logic                   arrived;

    modport source (output valid, new_x, new_y, arrived, input ready);
    modport sink   (input valid, new_x, new_y, arrived, output ready);
endinterface

FILE: src/mtt_mul.sv
// ---------------------------------------------------------------------------
// mtt_mul
// shared unsigned multiplier with registered product
// ---------------------------------------------------------------------------
module mtt_mul (
    input  logic                      i_clk,
    input  logic [mtt_pkg::MulAW-1:0] i_a,
    input  logic [mtt_pkg::StW-1:0]   i_b,
    output logic [mtt_pkg::NumW-1:0]  o_prod
);
    import mtt_pkg::*;

    logic [NumW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= NumW'(i_a) * NumW'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: src/mtt_sqrt.sv
// ---------------------------------------------------------------------------
// mtt_sqrt
// iterative floor square root, one root bit per cycle
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mtt_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mtt_pkg::SqW-1:0]   i_radicand,
    output mtt_pkg::t_unit_stat       o_stat,
    output logic [mtt_pkg::RootW-1:0] o_root
);
    import mtt_pkg::*;

    localparam int CntW = $clog2(RootSteps);
    localparam int RadW = 2 * RootW;
    localparam int RemW = RootW + 2;

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [RadW-1:0] r_rad;
    logic [RemW-1:0] r_rem;
    logic [RootW-1:0] r_root;

    logic [RemW-1:0] w_rem_sh;
    logic [RemW-1:0] w_trial;
    logic            w_ge;

    // bring down two radicand bits, try root*4+1
    assign w_rem_sh = {r_rem[RootW-1:0], r_rad[RadW-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_ge     = w_rem_sh >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(RootSteps - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RadW'(i_radicand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RadW-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[RootW-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;

    `ASSERT_NEXT(a_sqrt_start_runs, i_start, r_busy && !r_done)
    `ASSERT_NEXT(a_sqrt_done_pulse, r_done && !i_start, !r_done && !r_busy)

endmodule

FILE: src/mtt_div.sv
// ---------------------------------------------------------------------------
// mtt_div
// iterative restoring divider, |d| * st / (dist << 12), one quotient bit per cycle
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mtt_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mtt_pkg::NumW-1:0]  i_dividend,
    input  logic [mtt_pkg::RootW-1:0] i_dist,
    output mtt_pkg::t_unit_stat       o_stat,
    output logic [mtt_pkg::QuotW-1:0] o_quot
);
    import mtt_pkg::*;

    localparam int CntW = $clog2(DivSteps);

    logic             r_busy;
    logic             r_done;
    logic [CntW-1:0]  r_cnt;
    logic [NumW-1:0]  r_rem;
    logic [NumW-1:0]  r_dvs;
    logic [QuotW-1:0] r_quot;

    logic w_ge;

    assign w_ge = r_rem >= r_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(DivSteps - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // quotient is known to fit, so the divisor starts at its top aligned position
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dvs  <= NumW'({i_dist, {DvsShift{1'b0}}});
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (r_rem - r_dvs) : r_rem;
            r_dvs  <= r_dvs >> 1;
            r_quot <= {r_quot[QuotW-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

    `ASSERT_NEXT(a_div_start_runs, i_start, r_busy && !r_done)
    `ASSERT_NEXT(a_div_done_pulse, r_done && !i_start, !r_done && !r_busy)

endmodule

FILE: src/move_toward_target_step_unit.sv
// ---------------------------------------------------------------------------
// move_toward_target_step_unit
// fixed point 2-d stepper that moves a stored position toward a target
// ---------------------------------------------------------------------------
// The unit holds a q15.8 position (x, y), zero after reset. A load beat copies
// target_x/target_y into the position and returns it with arrived low. A step
// beat moves the position toward the target by speed * time_step along the
// unit direction: dist = floor(sqrt(dx^2 + dy^2)) and each axis moves by
// |d| * speed * time_step / (dist * 4096), truncated toward zero. If the new
// coordinate on the dominant axis (x when |dx| > |dy|) lands strictly past the
// target, the position snaps to the target and arrived is set; otherwise each
// coordinate saturates to the 24-bit range. A step with the position already
// on the target returns it unchanged with arrived set.
// Timing: one beat at a time; i_cmd.ready is low while a beat is in work. A
// step result runs through the shared multiplier (dx^2, dy^2, speed*time,
// |dx|*st, |dy|*st), the bit-serial square root (25 root bits), one
// bit-serial divider run twice (20 quotient bits each, x then y) and the
// commit state. A load or a step at the target goes straight to the commit
// state. Ready returns with the result. The result sits in an output
// register, so the next beat is accepted while a result waits to be taken;
// a finished beat holds in its commit state until the output register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module move_toward_target_step_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtt_in_if.sink     i_cmd,
    mtt_out_if.source  o_res
);
    import mtt_pkg::*;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ROOT = 6'b000100,
        S_DIVX = 6'b001000,
        S_DIVY = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    // multiplier slots
    localparam logic [2:0] MS_AXX = 3'd0;   // ax * ax
    localparam logic [2:0] MS_AYY = 3'd1;   // ay * ay, capture ax^2
    localparam logic [2:0] MS_ST  = 3'd2;   // speed * time, add ay^2
    localparam logic [2:0] MS_AXS = 3'd3;   // ax * st, capture st
    localparam logic [2:0] MS_AYS = 3'd4;   // ay * st, capture ax * st
    localparam logic [2:0] MS_END = 3'd5;   // capture ay * st, start root

    localparam int ExtW = PosW + 2;
    localparam logic signed [ExtW-1:0] PosMaxE = ExtW'(2 ** (PosW - 1) - 1);
    localparam logic signed [ExtW-1:0] PosMinE = ~PosMaxE;

    function automatic logic signed [PosW-1:0] sat_pos(input logic signed [ExtW-1:0] v);
        logic signed [PosW-1:0] res;
        if (v > PosMaxE) begin
            res = PosMaxE[PosW-1:0];
        end else if (v < PosMinE) begin
            res = PosMinE[PosW-1:0];
        end else begin
            res = v[PosW-1:0];
        end
        return res;
    endfunction

    t_state r_state;
    logic [2:0] r_step;

    // position and beat operands
    logic signed [PosW-1:0] r_cur_x, r_cur_y;
    logic signed [PosW-1:0] r_tx, r_ty;
    logic [SpdW-1:0]        r_speed;
    logic [TimeW-1:0]       r_time;
    logic [PosW-1:0]        r_ax, r_ay;
    logic                   r_sx, r_sy, r_xdom;

    // intermediate results
    logic [SqW-1:0]   r_sq;
    logic [StW-1:0]   r_st;
    logic [NumW-1:0]  r_num_x, r_num_y;
    logic [QuotW-1:0] r_qx;

    // pending result, committed in S_FIN
    logic signed [PosW-1:0] r_new_x, r_new_y;
    logic                   r_new_arr;

    // output register
    logic                   r_out_valid;
    logic signed [PosW-1:0] r_out_x, r_out_y;
    logic                   r_out_arr;

    // deltas of an incoming beat
    logic signed [PosW:0] w_dx, w_dy;
    logic [PosW-1:0]      w_ax, w_ay;
    logic                 w_accept;

    // shared units
    logic [MulAW-1:0] w_mul_a;
    logic [StW-1:0]   w_mul_b;
    logic [NumW-1:0]  w_prod;
    logic             w_sqrt_start;
    t_unit_stat       w_sqrt_stat;
    logic [RootW-1:0] w_root;
    logic             w_div_start;
    logic [NumW-1:0]  w_div_num;
    t_unit_stat       w_div_stat;
    logic [QuotW-1:0] w_quot;
    logic             w_div_phase;

    // final move
    logic signed [ExtW-1:0] w_mv_x, w_mv_y, w_nx, w_ny, w_tx_e, w_ty_e;
    logic                   w_arr;
    logic                   w_out_free;

    assign w_accept = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    assign w_dx = {i_cmd.target_x[PosW-1], i_cmd.target_x} - {r_cur_x[PosW-1], r_cur_x};
    assign w_dy = {i_cmd.target_y[PosW-1], i_cmd.target_y} - {r_cur_y[PosW-1], r_cur_y};
    // magnitudes stay below 2^24
    assign w_ax = w_dx[PosW] ? PosW'(-w_dx) : w_dx[PosW-1:0];
    assign w_ay = w_dy[PosW] ? PosW'(-w_dy) : w_dy[PosW-1:0];

    // multiplier operand select, st straight from the product for ax * st
    always_comb begin
        case (r_step)
            MS_AXX: begin
                w_mul_a = r_ax;
                w_mul_b = StW'(r_ax);
            end
            MS_AYY: begin
                w_mul_a = r_ay;
                w_mul_b = StW'(r_ay);
            end
            MS_ST: begin
                w_mul_a = MulAW'(r_speed);
                w_mul_b = StW'(r_time);
            end
            MS_AXS: begin
                w_mul_a = r_ax;
                w_mul_b = w_prod[StW-1:0];
            end
            MS_AYS: begin
                w_mul_a = r_ay;
                w_mul_b = r_st;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    mtt_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_sqrt_start = (r_state == S_MUL) && (r_step == MS_END);

    mtt_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (r_sq),
        .o_stat     (w_sqrt_stat),
        .o_root     (w_root)
    );

    // divider runs for x once the root is out, then again for y
    assign w_div_start = ((r_state == S_ROOT) && w_sqrt_stat.done) ||
                         ((r_state == S_DIVX) && w_div_stat.done);
    assign w_div_num   = (r_state == S_ROOT) ? r_num_x : r_num_y;
    assign w_div_phase = (r_state == S_DIVX) || (r_state == S_DIVY);

    mtt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_dist     (w_root),
        .o_stat     (w_div_stat),
        .o_quot     (w_quot)
    );

    // apply signed moves, y quotient taken as it leaves the divider
    assign w_mv_x = r_sx ? -ExtW'(r_qx)   : ExtW'(r_qx);
    assign w_mv_y = r_sy ? -ExtW'(w_quot) : ExtW'(w_quot);
    assign w_nx   = ExtW'(r_cur_x) + w_mv_x;
    assign w_ny   = ExtW'(r_cur_y) + w_mv_y;
    assign w_tx_e = ExtW'(r_tx);
    assign w_ty_e = ExtW'(r_ty);

    // overshoot on the dominant axis
    assign w_arr = r_xdom ? (r_sx ? (w_nx < w_tx_e) : (w_nx > w_tx_e))
                          : (r_sy ? (w_ny < w_ty_e) : (w_ny > w_ty_e));

    assign w_out_free = !r_out_valid || o_res.ready;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= MS_AXX;
            r_out_valid <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
        end else begin
            // output register fills on commit, empties when taken
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_step <= MS_AXX;
                        if (t_op'(i_cmd.operation) == OP_LOAD) begin
                            r_state <= S_FIN;
                        end else if (w_dx == '0 && w_dy == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (r_step == MS_END) begin
                        r_state <= S_ROOT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_ROOT: begin
                    if (w_sqrt_stat.done) begin
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    if (w_div_stat.done) begin
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (w_div_stat.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // commit once the output register is free
                    if (w_out_free) begin
                        r_cur_x     <= r_new_x;
                        r_cur_y     <= r_new_y;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tx    <= i_cmd.target_x;
            r_ty    <= i_cmd.target_y;
            r_speed <= i_cmd.speed;
            r_time  <= i_cmd.time_step;
            r_ax    <= w_ax;
            r_ay    <= w_ay;
            r_sx    <= w_dx[PosW];
            r_sy    <= w_dy[PosW];
            r_xdom  <= w_ax > w_ay;
            if (t_op'(i_cmd.operation) == OP_LOAD) begin
                r_new_x   <= i_cmd.target_x;
                r_new_y   <= i_cmd.target_y;
                r_new_arr <= 1'b0;
            end else begin
                // already on target, kept unless the full step runs
                r_new_x   <= r_cur_x;
                r_new_y   <= r_cur_y;
                r_new_arr <= 1'b1;
            end
        end

        if (r_state == S_MUL) begin
            case (r_step)
                MS_AYY:  r_sq    <= SqW'(w_prod);
                MS_ST:   r_sq    <= r_sq + SqW'(w_prod);
                MS_AXS:  r_st    <= w_prod[StW-1:0];
                MS_AYS:  r_num_x <= w_prod;
                MS_END:  r_num_y <= w_prod;
                default: ;
            endcase
        end

        if (r_state == S_DIVX && w_div_stat.done) begin
            r_qx <= w_quot;
        end

        if (r_state == S_DIVY && w_div_stat.done) begin
            r_new_arr <= w_arr;
            if (w_arr) begin
                r_new_x <= r_tx;
                r_new_y <= r_ty;
            end else begin
                r_new_x <= sat_pos(w_nx);
                r_new_y <= sat_pos(w_ny);
            end
        end

        if (r_state == S_FIN && w_out_free) begin
            r_out_x   <= r_new_x;
            r_out_y   <= r_new_y;
            r_out_arr <= r_new_arr;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.new_x   = r_out_x;
    assign o_res.new_y   = r_out_y;
    assign o_res.arrived = r_out_arr;

    `ASSERT_IMPLY(a_out_is_position, r_out_valid, (r_out_x == r_cur_x) && (r_out_y == r_cur_y))
    `ASSERT_IMPLY(a_root_in_work, r_state == S_ROOT, w_sqrt_stat.busy || w_sqrt_stat.done)
    `ASSERT_IMPLY(a_div_in_work, w_div_phase, w_div_stat.busy || w_div_stat.done)
    `ASSERT_NEXT(a_busy_after_beat, w_accept, !i_cmd.ready)

endmodule

FILE: bench/tb_move_toward_target_step_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_move_toward_target_step_unit
// self-checking bench for the fixed point move toward target stepper
// ---------------------------------------------------------------------------
// Command beats (loads and steps) go in over the command channel while a
// scoreboard object tracks its own copy of the position and predicts each
// result beat. Each result is compared field by field against the oldest
// prediction. A directed opening covers the range corners, zero motion, the
// at-target case, axis dominance and snapping. Random approach runs then load
// a start, pick a nearby goal and step toward it. Both channels stall at random.
// ---------------------------------------------------------------------------

class move_scoreboard;
    typedef struct packed {
        logic signed [mtt_pkg::PosW-1:0] x;
        logic signed [mtt_pkg::PosW-1:0] y;
        logic                            arrived;
    } t_position;

    longint    pos_x;
    longint    pos_y;
    t_position pending[$];
    int        errors;
    int        loads;
    int        steps;
    int        arrivals;
    int        stills;

    function new();
        pos_x    = 0;
        pos_y    = 0;
        errors   = 0;
        loads    = 0;
        steps    = 0;
        arrivals = 0;
        stills   = 0;
    endfunction

    // floor square root, digit by digit
    function longint floor_sqrt(longint n);
        longint root;
        longint b;
        root = 0;
        b    = longint'(1) <<< 50;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n    = n - (root + b);
                root = (root >>> 1) + b;
            end else begin
                root = root >>> 1;
            end
            b = b >>> 2;
        end
        return root;
    endfunction

    // per axis move, truncated toward zero
    function longint axis_delta(longint d, longint st, longint den);
        longint q;
        q = ((d < 0) ? -d : d) * st / den;
        return (d < 0) ? -q : q;
    endfunction

    function longint clamp_pos(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function void note_command(mtt_pkg::t_op op,
                               logic signed [mtt_pkg::PosW-1:0] tx,
                               logic signed [mtt_pkg::PosW-1:0] ty,
                               logic [mtt_pkg::SpdW-1:0] spd,
                               logic [mtt_pkg::TimeW-1:0] ts);
        longint    gx, gy, dx, dy, ax, ay, radius, st, nx, ny;
        logic      reached;
        t_position res;
        reached = 1'b0;
        gx      = longint'(tx);
        gy      = longint'(ty);
        if (op == mtt_pkg::OP_LOAD) begin
            pos_x = gx;
            pos_y = gy;
            loads++;
        end else begin
            steps++;
            dx = gx - pos_x;
            dy = gy - pos_y;
            if (dx == 0 && dy == 0) begin
                reached = 1'b1;
                stills++;
            end else begin
                ax     = (dx < 0) ? -dx : dx;
                ay     = (dy < 0) ? -dy : dy;
                radius = floor_sqrt(ax * ax + ay * ay);
                st     = longint'({48'd0, spd}) * longint'({48'd0, ts});
                nx     = pos_x + axis_delta(dx, st, radius <<< 12);
                ny     = pos_y + axis_delta(dy, st, radius <<< 12);
                if (ax > ay)
                    reached = (dx > 0) ? (nx > gx) : (nx < gx);
                else
                    reached = (dy > 0) ? (ny > gy) : (ny < gy);
                if (reached) begin
                    pos_x = gx;
                    pos_y = gy;
                    arrivals++;
                end else begin
                    pos_x = clamp_pos(nx);
                    pos_y = clamp_pos(ny);
                end
            end
        end
        res.x       = pos_x[mtt_pkg::PosW-1:0];
        res.y       = pos_y[mtt_pkg::PosW-1:0];
        res.arrived = reached;
        pending     = {pending, res};
    endfunction

    function void check_result(logic signed [mtt_pkg::PosW-1:0] x,
                               logic signed [mtt_pkg::PosW-1:0] y,
                               logic arrived);
        t_position want;
        if (pending.size() == 0) begin
            $display("%0t: result beat with nothing pending (x %0d y %0d arrived %0b)",
                     $time, x, y, arrived);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (x !== want.x) begin
            $display("%0t: new_x expected %0d got %0d", $time, want.x, x);
            errors++;
        end
        if (y !== want.y) begin
            $display("%0t: new_y expected %0d got %0d", $time, want.y, y);
            errors++;
        end
        if (arrived !== want.arrived) begin
            $display("%0t: arrived expected %0b got %0b", $time, want.arrived, arrived);
            errors++;
        end
    endfunction
endclass

module tb_move_toward_target_step_unit;
    import mtt_pkg::*;

    localparam int PosMax = 8388607;
    localparam int PosMin = -8388608;

    logic i_clk;
    logic i_rst_n;

    mtt_in_if  cmd_if();
    mtt_out_if res_if();

    move_toward_target_step_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    move_scoreboard sb;
    int             items_sent;
    int             stall_left;
    bit             calm;        // no gaps and no new stalls while set

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // stop with a failure if the run hangs
    initial begin
        #5ms;
        $display("timeout, %0d beats sent", items_sent);
        $display("FAILURE");
        $finish;
    end

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint fit_range(longint v);
        if (v > PosMax) return PosMax;
        if (v < PosMin) return PosMin;
        return v;
    endfunction

    // coordinate: mostly anywhere, now and then a range corner
    function automatic longint pick_coord();
        case ($urandom_range(0, 9))
            0:       return PosMax;
            1:       return PosMin;
            default: return longint'(signed'(24'($urandom)));
        endcase
    endfunction

    // signed offset with magnitude below 2^span
    function automatic longint jitter(int span);
        longint mag;
        mag = longint'($urandom_range(0, (1 << span) - 1));
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    // speed or time with a random scale so step sizes spread over many octaves
    function automatic logic [15:0] scaled16();
        return 16'($urandom_range(0, 65535) >> $urandom_range(0, 12));
    endfunction

    // result side backpressure, driven on the falling edge
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            res_if.ready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0)
                stall_left <= pick_gap();
        end
    end

    // both channels are watched on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready)
                sb.note_command(t_op'(cmd_if.operation), cmd_if.target_x,
                                cmd_if.target_y, cmd_if.speed, cmd_if.time_step);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.new_x, res_if.new_y, res_if.arrived);
        end
    end

    // one command beat; called and left on a falling edge
    task automatic send(input t_op op, input int tx, input int ty,
                        input logic [SpdW-1:0] spd, input logic [TimeW-1:0] ts);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.operation <= op;
        cmd_if.target_x  <= PosW'(tx);
        cmd_if.target_y  <= PosW'(ty);
        cmd_if.speed     <= spd;
        cmd_if.time_step <= ts;
        do @(posedge i_clk); while (!cmd_if.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic directed_opening();
        // step right after reset, position already on the target
        send(OP_STEP, 0, 0, 16'h0010, 16'h1000);
        // corners of the range
        send(OP_LOAD, PosMax, PosMin, 16'hffff, 16'hffff);
        send(OP_STEP, PosMax, PosMin, 16'hffff, 16'hffff);
        send(OP_STEP, PosMin, PosMax, 16'hffff, 16'hffff);
        // zero speed, then zero time: truncated move is zero
        send(OP_STEP, PosMin, PosMax, 16'h0000, 16'hffff);
        send(OP_STEP, PosMin, PosMax, 16'hffff, 16'h0000);
        // falls just short along x, then overshoots and snaps
        send(OP_LOAD, 0, 0, 16'h0000, 16'h0000);
        send(OP_STEP, 256, 0, 16'h0010, 16'hffff);
        send(OP_STEP, 256, 0, 16'h0010, 16'hffff);
        // exact diagonal, y decides arrival
        send(OP_LOAD, 0, 0, 16'h0000, 16'h0000);
        send(OP_STEP, -1000, -1000, 16'h0100, 16'h8000);
        // negative x travel, small y move truncates to zero
        send(OP_LOAD, 5000, 0, 16'h0000, 16'h0000);
        send(OP_STEP, -5000, 7, 16'h0040, 16'h4000);
        send(OP_STEP, -5000, 7, 16'hffff, 16'hffff);
        send(OP_STEP, -5000, 7, 16'h1234, 16'h5678);
        // pure negative y travel from the top edge
        send(OP_LOAD, -3, PosMax, 16'h0000, 16'h0000);
        send(OP_STEP, -3, PosMin, 16'h1234, 16'h5678);
        // full diagonal sweep at top speed
        send(OP_LOAD, PosMin, PosMin, 16'h0000, 16'h0000);
        send(OP_STEP, PosMax, PosMax, 16'hffff, 16'hffff);
        send(OP_STEP, PosMax, PosMax, 16'hffff, 16'hffff);
        // short hop that arrives from far away in one beat
        send(OP_LOAD, 100000, -100000, 16'h0000, 16'h0000);
        send(OP_STEP, 0, 0, 16'hffff, 16'hffff);
    endtask

    // load a start, pick a goal near it and step toward it a few times
    task automatic approach_run();
        longint sx, sy, gx, gy;
        int     span;
        int     hops;
        sx   = pick_coord();
        sy   = pick_coord();
        send(OP_LOAD, int'(sx), int'(sy), scaled16(), scaled16());
        span = $urandom_range(2, 22);
        gx   = ($urandom_range(0, 5) == 0) ? sx : fit_range(sx + jitter(span));
        gy   = ($urandom_range(0, 5) == 0) ? sy : fit_range(sy + jitter(span));
        hops = $urandom_range(1, 8);
        repeat (hops) begin
            // now and then the goal moves mid run
            if ($urandom_range(0, 7) == 0) begin
                gx = fit_range(gx + jitter(span));
                gy = fit_range(gy + jitter(span));
            end
            send(OP_STEP, int'(gx), int'(gy), scaled16(), scaled16());
        end
    endtask

    initial begin
        sb               = new();
        items_sent       = 0;
        stall_left       = 0;
        calm             = 1'b0;
        i_rst_n          = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.operation = OP_LOAD;
        cmd_if.target_x  = '0;
        cmd_if.target_y  = '0;
        cmd_if.speed     = '0;
        cmd_if.time_step = '0;
        res_if.ready     = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_opening();

        // mostly approach runs, the rest raw random beats
        while (items_sent < 400) begin
            if ($urandom_range(0, 9) == 0) calm = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 4) == 0)
                send(t_op'($urandom_range(0, 1)), int'(pick_coord()), int'(pick_coord()),
                     16'($urandom), 16'($urandom));
            else
                approach_run();
        end
        cmd_if.valid <= 1'b0;
        calm = 1'b0;

        // drain, then give a late extra result room to show up
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        $display("ran %0d loads and %0d steps: %0d snapped to the target, %0d already on it",
                 sb.loads, sb.steps, sb.arrivals, sb.stills);
        $display("%0d mismatches", sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+src
src/mtt_pkg.sv
src/mtt_in_if.sv
src/mtt_out_if.sv
src/mtt_mul.sv
src/mtt_sqrt.sv
src/mtt_div.sv
src/move_toward_target_step_unit.sv
bench/tb_move_toward_target_step_unit.sv
